/* sv/bcu_pkg.sv */
// bcu_pkg: shared constants, width helpers and types for the block color uniformity test
// used by every module of the block; no dependencies
`default_nettype none

package bcu_pkg;

  localparam int unsigned MAX_SIDE_DEF = 64;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned ERR_W        = 16;
  localparam int unsigned SIDE_REG_W   = 7;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIDE = 2'd1;

  // pixel count width: holds up to max_side squared
  function automatic int unsigned cnt_w(input int unsigned max_side);
    return $clog2(max_side * max_side + 1);
  endfunction

  // width of one block snapshot: count, three sums, three sums of squares
  function automatic int unsigned snap_w(input int unsigned max_side);
    int unsigned cw;
    cw = cnt_w(max_side);
    return cw + 3 * (cw + PIX_W) + 3 * (cw + 2 * PIX_W);
  endfunction

  typedef struct packed {
    logic             is_uniform;
    logic [PIX_W-1:0] mean_red;
    logic [PIX_W-1:0] mean_green;
    logic [PIX_W-1:0] mean_blue;
    logic [ERR_W-1:0] block_error;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

/* sv/bcu_front.sv */
// bcu_front: accumulates pixel sums and sums of squares, detects the last pixel of a block
// and hands a snapshot of the block to the queue; uses bcu_pkg
`default_nettype none

module bcu_front
  import bcu_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF,
  parameter int unsigned EFF_W    = 7
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [PIX_W-1:0]             pixel_red_i,
  input  wire logic [PIX_W-1:0]             pixel_green_i,
  input  wire logic [PIX_W-1:0]             pixel_blue_i,
  input  wire logic [EFF_W-1:0]             side_i,
  input  wire logic                         q_full_i,
  output logic                              q_push_o,
  output logic [snap_w(MAX_SIDE)-1:0]       q_data_o
);

  localparam int unsigned CNT_W = cnt_w(MAX_SIDE);
  localparam int unsigned SUM_W = CNT_W + PIX_W;
  localparam int unsigned SQ_W  = CNT_W + 2 * PIX_W;

  logic [CNT_W-1:0]     cnt_q, cnt_nx;
  logic [SUM_W-1:0]     sum_q [3];
  logic [SUM_W-1:0]     sum_nx [3];
  logic [SQ_W-1:0]      sq_q [3];
  logic [SQ_W-1:0]      sq_nx [3];
  logic [PIX_W-1:0]     pix [3];
  logic [2*PIX_W-1:0]   pix_sq [3];
  logic [2*EFF_W-1:0]   limit;
  logic                 last;
  logic                 accept;

  assign pix[0] = pixel_red_i;
  assign pix[1] = pixel_green_i;
  assign pix[2] = pixel_blue_i;

  assign limit  = side_i * side_i;
  assign cnt_nx = cnt_q + CNT_W'(1);
  assign last   = cnt_nx >= limit;

  // only the pixel that closes a block needs room in the queue
  assign full   = q_full_i && last;
  assign accept = push && !full;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pix_sq[c] = pix[c] * pix[c];
      sum_nx[c] = sum_q[c] + SUM_W'(pix[c]);
      sq_nx[c]  = sq_q[c] + SQ_W'(pix_sq[c]);
    end
  end

  always_comb begin
    q_data_o[3*SQ_W+3*SUM_W +: CNT_W] = cnt_nx;
    for (int c = 0; c < 3; c++) begin
      q_data_o[3*SQ_W + (2-c)*SUM_W +: SUM_W] = sum_nx[c];
      q_data_o[(2-c)*SQ_W +: SQ_W]            = sq_nx[c];
    end
  end

  assign q_push_o = accept && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= '0;
        sq_q[c]  <= '0;
      end
    end else if (accept) begin
      if (last) begin
        cnt_q <= '0;
        for (int c = 0; c < 3; c++) begin
          sum_q[c] <= '0;
          sq_q[c]  <= '0;
        end
      end else begin
        cnt_q <= cnt_nx;
        for (int c = 0; c < 3; c++) begin
          sum_q[c] <= sum_nx[c];
          sq_q[c]  <= sq_nx[c];
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/bcu_queue.sv */
// bcu_queue: short register queue of block snapshots between front and back
// uses bcu_pkg for the status struct and the default depth
`default_nettype none

module bcu_queue
  import bcu_pkg::*;
#(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  input  wire logic              pop_i,
  output logic [DATA_W-1:0]      data_o,
  output qstat_t                 stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign stat_o.full  = count_q == CNT_W'(DEPTH);
  assign stat_o.empty = count_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/bcu_back.sv */
// bcu_back: per-block arithmetic; channel means by an 8-step divider, deviation from
// the sums with one multiplier, error by a 16-step divide; holds the result register; uses bcu_pkg
`default_nettype none

module bcu_back
  import bcu_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_empty_i,
  input  wire logic [snap_w(MAX_SIDE)-1:0]  q_data_i,
  output logic                              q_pop_o,
  input  wire logic [CFG_DATA_W-1:0]        threshold_i,
  input  wire logic                         pop,
  output logic                              empty,
  output res_t                              res_o
);

  localparam int unsigned CNT_W  = cnt_w(MAX_SIDE);
  localparam int unsigned SUM_W  = CNT_W + PIX_W;
  localparam int unsigned SQ_W   = CNT_W + 2 * PIX_W;
  localparam int unsigned TOT_W  = SQ_W + 2;
  localparam int unsigned REM_W  = CNT_W + 2;
  localparam int unsigned STEP_W = $clog2(ERR_W);
  localparam int unsigned PROD_W = SUM_W + 1 + PIX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MDIV,
    ST_MUL,
    ST_ACC,
    ST_ESET,
    ST_EDIV,
    ST_OUT
  } state_e;

  state_e              state_q;
  logic                out_valid_q;
  logic [1:0]          ch_q;
  logic [STEP_W-1:0]   step_q;

  logic [CNT_W-1:0]    n_q;
  logic [SUM_W-1:0]    s_q [3];
  logic [SQ_W-1:0]     sqs_q [3];
  logic [PIX_W-1:0]    mean_q [3];
  logic [REM_W-1:0]    rem_q;
  logic [ERR_W-1:0]    quo_q;
  logic [SQ_W-1:0]     prod_q;
  logic [TOT_W-1:0]    tot_q;
  res_t                res_q;

  // divider step
  logic [REM_W-1:0]    n3;
  logic [REM_W-1:0]    dvsr;
  logic [REM_W:0]      trial;
  logic                ge;
  logic [REM_W-1:0]    rem_nx;
  logic [ERR_W-1:0]    quo_nx;
  logic [SUM_W:0]      s_plus_r;
  logic [PROD_W-1:0]   prod_full;
  logic [SQ_W-1:0]     dev;
  logic                out_free;

  assign n3     = REM_W'({n_q, 1'b0}) + REM_W'(n_q);
  assign dvsr   = (state_q == ST_EDIV) ? n3 : REM_W'(n_q);
  assign trial  = {rem_q, quo_q[ERR_W-1]};
  assign ge     = trial >= {1'b0, dvsr};
  assign rem_nx = ge ? REM_W'(trial - {1'b0, dvsr}) : REM_W'(trial);
  assign quo_nx = {quo_q[ERR_W-2:0], ge};

  // with r = s mod n the channel deviation n*m*m + q - 2*m*s reduces to q - m*(s + r)
  assign s_plus_r  = {1'b0, s_q[ch_q]} + (SUM_W + 1)'(rem_q[CNT_W-1:0]);
  assign prod_full = mean_q[ch_q] * s_plus_r;
  assign dev       = sqs_q[ch_q] - prod_q;

  assign out_free = !out_valid_q || pop;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign empty    = !out_valid_q;
  assign res_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
      step_q      <= '0;
    end else begin
      // in the output state a pop is covered by the refill below
      if (pop && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            ch_q    <= '0;
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          step_q  <= '0;
          state_q <= ST_MDIV;
        end
        ST_MDIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(PIX_W - 1)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (ch_q == 2'd2) begin
            state_q <= ST_ESET;
          end else begin
            ch_q    <= ch_q + 2'd1;
            state_q <= ST_SETUP;
          end
        end
        ST_ESET: begin
          step_q  <= '0;
          state_q <= ST_EDIV;
        end
        ST_EDIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(ERR_W - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          n_q   <= q_data_i[3*SQ_W+3*SUM_W +: CNT_W];
          tot_q <= '0;
          for (int c = 0; c < 3; c++) begin
            s_q[c]   <= q_data_i[3*SQ_W + (2-c)*SUM_W +: SUM_W];
            sqs_q[c] <= q_data_i[(2-c)*SQ_W +: SQ_W];
          end
        end
      end
      ST_SETUP: begin
        // the mean fits in 8 bits, so the top of the sum is already below n
        rem_q <= REM_W'(s_q[ch_q][SUM_W-1:PIX_W]);
        quo_q <= {s_q[ch_q][PIX_W-1:0], (ERR_W - PIX_W)'(0)};
      end
      ST_MDIV: begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        if (step_q == STEP_W'(PIX_W - 1)) begin
          mean_q[ch_q] <= quo_nx[PIX_W-1:0];
        end
      end
      ST_MUL: begin
        prod_q <= prod_full[SQ_W-1:0];
      end
      ST_ACC: begin
        tot_q <= tot_q + TOT_W'(dev);
      end
      ST_ESET: begin
        // error stays below 2^16, so the upper part of the total is below 3n
        rem_q <= tot_q[ERR_W +: REM_W];
        quo_q <= tot_q[ERR_W-1:0];
      end
      ST_EDIV: begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
      end
      ST_OUT: begin
        if (out_free) begin
          res_q.is_uniform  <= quo_q <= threshold_i;
          res_q.mean_red    <= mean_q[0];
          res_q.mean_green  <= mean_q[1];
          res_q.mean_blue   <= mean_q[2];
          res_q.block_error <= quo_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/block_color_uniformity_test.sv */
// Block color uniformity test.
// Pixels of one square block enter on the push/full side, one per cycle while full is low, in any order.
// A pixel transfer happens when push is high and full is low; full rises only when the
// incoming pixel would close a block and the snapshot queue (two blocks deep) is full.
// After the last pixel of a block one result appears on the empty/pop side: the three
// truncated channel means, the mean squared error and the uniform flag (error at most
// threshold). Results wait in an output register until popped; a stalled receiver
// backs up the snapshot queue and then the last pixel of the next blocks, never the others.
// The back end handles one snapshot at a time and takes the next only when back in idle:
// per channel a mean divide, a multiply and an accumulate step, then the error divide, so
// pixels stream at one per cycle for large blocks while small blocks wait on the back end.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 threshold, 1 block_side);
// ready is always high. block_side keeps data bits 6:0 only; 0 counts as 1, values above
// MAX_SIDE (but at most 127) as that limit. Reset clears the accumulators, the queue and the
// result valid flag; threshold resets to 0 and block_side to 1.
// Depends on bcu_pkg, bcu_front, bcu_queue and bcu_back.
`default_nettype none

module block_color_uniformity_test
  import bcu_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [PIX_W-1:0]      pixel_red_i,
  input  wire logic [PIX_W-1:0]      pixel_green_i,
  input  wire logic [PIX_W-1:0]      pixel_blue_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic                       is_uniform_o,
  output logic [PIX_W-1:0]           mean_red_o,
  output logic [PIX_W-1:0]           mean_green_o,
  output logic [PIX_W-1:0]           mean_blue_o,
  output logic [ERR_W-1:0]           block_error_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SIDE_CAP = (MAX_SIDE < 127) ? MAX_SIDE : 127;
  localparam int unsigned EFF_W    = $clog2(SIDE_CAP + 1);
  localparam int unsigned SNAP_W   = snap_w(MAX_SIDE);

  logic [CFG_DATA_W-1:0] threshold_q;
  logic [SIDE_REG_W-1:0] block_side_q;
  logic [EFF_W-1:0]      side_eff;

  logic                  q_push, q_pop;
  logic [SNAP_W-1:0]     q_wdata, q_rdata;
  qstat_t                q_stat;
  res_t                  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= '0;
      block_side_q <= SIDE_REG_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD:  threshold_q  <= cfg_data_i;
        CFG_BLOCK_SIDE: block_side_q <= cfg_data_i[SIDE_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (block_side_q == '0) begin
      side_eff = EFF_W'(1);
    end else if (32'(block_side_q) > SIDE_CAP) begin
      side_eff = EFF_W'(SIDE_CAP);
    end else begin
      side_eff = EFF_W'(block_side_q);
    end
  end

  bcu_front #(
    .MAX_SIDE (MAX_SIDE),
    .EFF_W    (EFF_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .side_i        (side_eff),
    .q_full_i      (q_stat.full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  bcu_queue #(
    .DATA_W (SNAP_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  bcu_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_stat.empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .threshold_i (threshold_q),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res)
  );

  assign is_uniform_o  = res.is_uniform;
  assign mean_red_o    = res.mean_red;
  assign mean_green_o  = res.mean_green;
  assign mean_blue_o   = res.mean_blue;
  assign block_error_o = res.block_error;

  // input side stalls only on a full snapshot queue
  a_full_needs_queue_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni) full |-> q_stat.full
  ) else $error("full raised while snapshot queue has room");

  // a closing pixel is never pushed into a full queue
  a_no_push_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full
  ) else $error("snapshot pushed into full queue");

  // back end takes a snapshot only when one is present
  a_no_pop_when_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty
  ) else $error("snapshot taken from empty queue");

endmodule

`default_nettype wire
